// ===== hdl/ssp_pkg.sv =====
`default_nettype none

package ssp_pkg;

	localparam int DEFAULT_VALUE_WIDTH = 64;
	localparam int SIZE_WIDTH          = 64;
	localparam int DEFAULT_QUEUE_DEPTH = 4;
	localparam int UNIT_COUNT          = 8;
	localparam int POWER_W             = 4;
	localparam int ACC_GROW            = 4;
	localparam int SCALE_GROW          = 10;
	localparam int BIN_SHIFT           = 10;
	localparam int BASE_DEC            = 1000;
	localparam int BIT_SHIFT           = 3;
	localparam logic [7:0] CASE_OFFSET = 8'd32;

	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_NINE  = "9";
	localparam logic [7:0] CH_BIN   = "i";
	localparam logic [7:0] CH_BITS  = "b";
	localparam logic [7:0] CH_BYTES = "B";

	localparam logic [7:0] UNIT_LETTERS [UNIT_COUNT] = '{"K", "M", "G", "T", "P", "E", "Z", "Y"};

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} char_req_t;

	typedef struct packed {
		logic [SIZE_WIDTH-1:0] size_value;
		logic                  invalid;
		logic                  overflow;
	} size_rsp_t;

	typedef struct packed {
		logic [POWER_W-1:0] power;
		logic               binary;
		logic               bits;
		logic               invalid;
		logic               overflow;
	} job_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// 1..8 for a unit letter in either case, 0 otherwise
	function automatic logic [POWER_W-1:0] unit_of(input logic [7:0] c);
		logic [POWER_W-1:0] u;
		u = '0;
		for (int j = 0; j < UNIT_COUNT; j++) begin
			if (c == UNIT_LETTERS[j] || c == UNIT_LETTERS[j] + CASE_OFFSET) begin
				u = POWER_W'(j + 1);
			end
		end
		return u;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ssp_stream_if.sv =====
`default_nettype none

interface ssp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/ssp_front.sv =====
`default_nettype none

module ssp_front #(
	parameter int VALUE_WIDTH = ssp_pkg::DEFAULT_VALUE_WIDTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	ssp_stream_if.sink            char_in,
	input  wire ssp_pkg::q_status_t q_status,
	output logic                  push,
	output logic [VALUE_WIDTH-1:0] push_acc,
	output ssp_pkg::job_ctl_t     push_ctl
);

	localparam int WIDE_W = VALUE_WIDTH + ssp_pkg::ACC_GROW;

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_DIGITS,
		PH_UNIT,
		PH_BIN,
		PH_DONE
	} phase_t;

	phase_t                     phase_q, phase_nxt;
	logic [VALUE_WIDTH-1:0]     acc_q, acc_nxt;
	ssp_pkg::job_ctl_t          ctl_q, ctl_nxt;
	logic [WIDE_W-1:0]          acc_wide;
	logic [ssp_pkg::POWER_W-1:0] unit;
	logic [7:0]                 c;
	logic                       digit;
	logic                       accept;

	assign c       = char_in.data.char_code;
	assign char_in.ready = !q_status.full;
	assign accept  = char_in.valid && char_in.ready;
	assign push    = accept && char_in.data.last_char;
	assign digit   = (c >= ssp_pkg::CH_ZERO) && (c <= ssp_pkg::CH_NINE);
	assign unit    = ssp_pkg::unit_of(c);
	// acc * 10 + digit, kept wide so the carry-out flags overflow
	assign acc_wide = ({{ssp_pkg::ACC_GROW{1'b0}}, acc_q} << 3)
		+ ({{ssp_pkg::ACC_GROW{1'b0}}, acc_q} << 1)
		+ WIDE_W'(c[3:0]);

	always_comb begin
		phase_nxt = phase_q;
		acc_nxt   = acc_q;
		ctl_nxt   = ctl_q;
		if (!ctl_q.invalid) begin
			if (digit && (phase_q == PH_FIRST || phase_q == PH_DIGITS)) begin
				acc_nxt   = acc_wide[VALUE_WIDTH-1:0];
				phase_nxt = PH_DIGITS;
				if (acc_wide[WIDE_W-1:VALUE_WIDTH] != '0) begin
					ctl_nxt.overflow = 1'b1;
				end
			end else if (phase_q == PH_FIRST) begin
				ctl_nxt.invalid = 1'b1;
			end else if (phase_q == PH_DIGITS && unit != '0) begin
				ctl_nxt.power = unit;
				phase_nxt     = PH_UNIT;
			end else if ((phase_q == PH_DIGITS || phase_q == PH_UNIT)
				&& c == ssp_pkg::CH_BIN) begin
				ctl_nxt.binary = 1'b1;
				phase_nxt      = PH_BIN;
			end else if (phase_q != PH_DONE
				&& (c == ssp_pkg::CH_BITS || c == ssp_pkg::CH_BYTES)) begin
				ctl_nxt.bits = (c == ssp_pkg::CH_BITS);
				phase_nxt    = PH_DONE;
			end else begin
				ctl_nxt.invalid = 1'b1;
			end
		end
	end

	assign push_acc = acc_nxt;
	assign push_ctl = ctl_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			acc_q   <= '0;
			ctl_q   <= '0;
		end else if (accept) begin
			if (char_in.data.last_char) begin
				phase_q <= PH_FIRST;
				acc_q   <= '0;
				ctl_q   <= '0;
			end else begin
				phase_q <= phase_nxt;
				acc_q   <= acc_nxt;
				ctl_q   <= ctl_nxt;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ssp_queue.sv =====
`default_nettype none

module ssp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = ssp_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic          pop,
	output logic [WIDTH-1:0]   head_data,
	output ssp_pkg::q_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign status.full  = (cnt_q == CNT_W'(DEPTH));
	assign status.empty = (cnt_q == '0);
	assign head_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ssp_back.sv =====
`default_nettype none

module ssp_back #(
	parameter int VALUE_WIDTH = ssp_pkg::DEFAULT_VALUE_WIDTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ssp_pkg::q_status_t q_status,
	input  wire logic [VALUE_WIDTH-1:0] head_acc,
	input  wire ssp_pkg::job_ctl_t head_ctl,
	output logic                   pop,
	ssp_stream_if.source           size_out
);

	localparam int NST    = ssp_pkg::UNIT_COUNT;
	localparam int WIDE_W = VALUE_WIDTH + ssp_pkg::SCALE_GROW;

	// stage k applies the k-th power step; stage 0 is the queue head
	logic [VALUE_WIDTH-1:0] val_s [NST+1];
	ssp_pkg::job_ctl_t      ctl_s [NST+1];
	logic                   vld_s [NST+1];
	logic [VALUE_WIDTH-1:0] val_nxt [NST];
	ssp_pkg::job_ctl_t      ctl_nxt [NST];
	logic [WIDE_W-1:0]      prod [NST];
	logic [VALUE_WIDTH-1:0] fin_val;
	logic                   adv;
	ssp_pkg::size_rsp_t     rsp_q;
	logic                   rsp_vld_q;

	assign adv = !rsp_vld_q || size_out.ready;
	assign pop = adv && !q_status.empty;

	always_comb begin
		for (int k = 0; k < NST; k++) begin
			val_nxt[k] = val_s[k];
			ctl_nxt[k] = ctl_s[k];
			if (ctl_s[k].binary) begin
				prod[k] = {{ssp_pkg::SCALE_GROW{1'b0}}, val_s[k]} << ssp_pkg::BIN_SHIFT;
			end else begin
				prod[k] = {{ssp_pkg::SCALE_GROW{1'b0}}, val_s[k]}
					* WIDE_W'(ssp_pkg::BASE_DEC);
			end
			if (!ctl_s[k].invalid && ctl_s[k].power > ssp_pkg::POWER_W'(k)) begin
				val_nxt[k] = prod[k][VALUE_WIDTH-1:0];
				if (prod[k][WIDE_W-1:VALUE_WIDTH] != '0) begin
					ctl_nxt[k].overflow = 1'b1;
				end
			end
		end
	end

	assign fin_val = ctl_s[NST].bits ? (val_s[NST] >> ssp_pkg::BIT_SHIFT) : val_s[NST];

	always_ff @(posedge clk) begin
		if (adv) begin
			val_s[0] <= head_acc;
			ctl_s[0] <= head_ctl;
			for (int k = 0; k < NST; k++) begin
				val_s[k+1] <= val_nxt[k];
				ctl_s[k+1] <= ctl_nxt[k];
			end
			if (ctl_s[NST].invalid) begin
				rsp_q.size_value <= '0;
				rsp_q.invalid    <= 1'b1;
				rsp_q.overflow   <= 1'b0;
			end else begin
				rsp_q.size_value <= ssp_pkg::SIZE_WIDTH'(fin_val);
				rsp_q.invalid    <= 1'b0;
				rsp_q.overflow   <= ctl_s[NST].overflow;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NST; k++) begin
				vld_s[k] <= 1'b0;
			end
			rsp_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= !q_status.empty;
			for (int k = 0; k < NST; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
			rsp_vld_q <= vld_s[NST];
		end
	end

	assign size_out.valid = rsp_vld_q;
	assign size_out.data  = rsp_q;

endmodule

`default_nettype wire

// ===== hdl/size_string_parser.sv =====
// Path: job queue, head register, eight unit-scaling stages, output register.
// Throughput: one character per cycle while the job queue is not full, one
//   result per cycle while the output is not stalled; the scaling pipeline
//   takes a new job every unstalled cycle, the 4-entry job queue absorbs stalls.
// Reset: arst_n asynchronous; clears parser state, queue pointers, valid bits.
`default_nettype none

module size_string_parser #(
	parameter int VALUE_WIDTH = ssp_pkg::DEFAULT_VALUE_WIDTH,
	parameter int QUEUE_DEPTH = ssp_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	ssp_stream_if.sink   char_in,
	ssp_stream_if.source size_out
);

	localparam int JOB_W = VALUE_WIDTH + $bits(ssp_pkg::job_ctl_t);

	ssp_pkg::q_status_t     q_status;
	logic                   push;
	logic                   pop;
	logic [VALUE_WIDTH-1:0] push_acc;
	ssp_pkg::job_ctl_t      push_ctl;
	logic [JOB_W-1:0]       head_data;
	logic [VALUE_WIDTH-1:0] head_acc;
	ssp_pkg::job_ctl_t      head_ctl;

	ssp_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_in (char_in),
		.q_status(q_status),
		.push    (push),
		.push_acc(push_acc),
		.push_ctl(push_ctl)
	);

	ssp_queue #(
		.WIDTH(JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_acc, push_ctl}),
		.pop      (pop),
		.head_data(head_data),
		.status   (q_status)
	);

	assign head_acc = head_data[JOB_W-1:$bits(ssp_pkg::job_ctl_t)];
	assign head_ctl = head_data[$bits(ssp_pkg::job_ctl_t)-1:0];

	ssp_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_status(q_status),
		.head_acc(head_acc),
		.head_ctl(head_ctl),
		.pop     (pop),
		.size_out(size_out)
	);

`ifndef SYNTHESIS
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("job pushed into full queue");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("job popped from empty queue");

	a_stall_blocks_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(size_out.valid && !size_out.ready) |-> !pop)
		else $error("queue popped while result stalled");

	a_invalid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(size_out.valid && size_out.data.invalid)
		|-> (size_out.data.size_value == '0 && !size_out.data.overflow))
		else $error("invalid result carries value or overflow");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;
	import ssp_pkg::*;

	localparam int RANDOM_CHARS = 1830;
	localparam int TAIL_CHARS   = 300;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 30;
	localparam int CYCLE_LIMIT  = 400000;
	localparam logic [63:0] ALL_ONES = '1;

	typedef enum bit [2:0] {
		EXPECT_FIRST,
		IN_DIGITS,
		AFTER_UNIT,
		AFTER_BIN,
		AFTER_BYTE
	} parse_phase_t;

	typedef bit [7:0] text_t[$];

	// predicts each parsed size and holds the sizes still owed by the block
	class size_scoreboard;
		bit [63:0]    number;
		parse_phase_t phase;
		bit [3:0]     power;
		bit           binary;
		bit           in_bits;
		bit           malformed;
		bit           wrapped;
		size_rsp_t    owed_sizes[$];
		int           errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			number    = '0;
			phase     = EXPECT_FIRST;
			power     = '0;
			binary    = 1'b0;
			in_bits   = 1'b0;
			malformed = 1'b0;
			wrapped   = 1'b0;
		endfunction

		function int pending();
			return owed_sizes.size();
		endfunction

		function bit [3:0] letter_power(bit [7:0] c);
			bit [3:0] p;
			p = '0;
			for (int j = 0; j < UNIT_COUNT; j++) begin
				if (c == UNIT_LETTERS[j] || c == 8'(UNIT_LETTERS[j] + CASE_OFFSET)) begin
					p = 4'(j + 1);
				end
			end
			return p;
		endfunction

		// anything out of the order unit, 'i', 'b'/'B' marks the string bad
		function void take_suffix(bit [7:0] c);
			bit [3:0] p;
			p = letter_power(c);
			if (phase == IN_DIGITS && p != 0) begin
				power = p;
				phase = AFTER_UNIT;
			end else if ((phase == IN_DIGITS || phase == AFTER_UNIT) && c == CH_BIN) begin
				binary = 1'b1;
				phase  = AFTER_BIN;
			end else if (phase != AFTER_BYTE && (c == CH_BITS || c == CH_BYTES)) begin
				if (c == CH_BITS) begin
					in_bits = 1'b1;
				end
				phase = AFTER_BYTE;
			end else begin
				malformed = 1'b1;
			end
		endfunction

		function void note_request(char_req_t req);
			bit [7:0]  c;
			bit [63:0] d;
			bit [63:0] base;
			bit [63:0] v;
			bit        o;
			size_rsp_t sz;
			c = req.char_code;
			if (!malformed) begin
				if (c >= CH_ZERO && c <= CH_NINE && (phase == EXPECT_FIRST || phase == IN_DIGITS)) begin
					d = 64'(c - CH_ZERO);
					if (number > (ALL_ONES - d) / 10) begin
						wrapped = 1'b1;
					end
					number = number * 64'd10 + d;
					phase  = IN_DIGITS;
				end else if (phase == EXPECT_FIRST) begin
					malformed = 1'b1;
				end else begin
					take_suffix(c);
				end
			end
			if (req.last_char) begin
				if (malformed) begin
					sz = '{size_value: '0, invalid: 1'b1, overflow: 1'b0};
				end else begin
					base = binary ? 64'd1024 : 64'(BASE_DEC);
					v = number;
					o = wrapped;
					for (int k = 0; k < power && k < UNIT_COUNT; k++) begin
						if (v > ALL_ONES / base) begin
							o = 1'b1;
						end
						v = v * base;
					end
					// scaling a zero never wraps
					if (number == 0) begin
						o = wrapped;
					end
					if (in_bits) begin
						v = v >> BIT_SHIFT;
					end
					sz = '{size_value: v, invalid: 1'b0, overflow: o};
				end
				owed_sizes.push_back(sz);
				restart();
			end
		endfunction

		function void check_result(size_rsp_t got);
			size_rsp_t want;
			if (owed_sizes.size() == 0) begin
				$display("%0t: unexpected result size_value=%h invalid=%b overflow=%b",
					$time, got.size_value, got.invalid, got.overflow);
				errors++;
				return;
			end
			want = owed_sizes.pop_front();
			if (got.size_value !== want.size_value) begin
				$display("%0t: size_value expected %h actual %h",
					$time, want.size_value, got.size_value);
				errors++;
			end
			if (got.invalid !== want.invalid) begin
				$display("%0t: invalid expected %b actual %b", $time, want.invalid, got.invalid);
				errors++;
			end
			if (got.overflow !== want.overflow) begin
				$display("%0t: overflow expected %b actual %b", $time, want.overflow, got.overflow);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ssp_stream_if #(.payload_t(char_req_t)) char_if ();
	ssp_stream_if #(.payload_t(size_rsp_t)) size_if ();

	size_string_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_in  (char_if),
		.size_out (size_if)
	);

	size_scoreboard sb;
	int  cycles      = 0;
	int  chars_sent  = 0;
	int  tx_pct      = 0;
	bit  hold_go     = 1'b0;
	bit  hold_done   = 1'b0;
	bit  tail_phase  = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && char_if.valid && char_if.ready) begin
			sb.note_request(char_if.data);
		end
		if (arst_n && size_if.valid && size_if.ready) begin
			sb.check_result(size_if.data);
		end
	end

	// result side: short random stalls, one long hold-off on request
	initial begin
		int stall_left;
		int rx_pct;
		int rx_cycle;
		stall_left = 0;
		rx_pct = 0;
		rx_cycle = 0;
		size_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
			end else if (hold_go && !hold_done) begin
				size_if.ready <= 1'b0;
				stall_left = HOLD_CYCLES - 1;
				hold_done = 1'b1;
			end else if (!tail_phase && $urandom_range(99, 0) < rx_pct) begin
				size_if.ready <= 1'b0;
				stall_left = $urandom_range(5, 1) - 1;
			end else begin
				size_if.ready <= 1'b1;
			end
			rx_cycle++;
			if (rx_cycle % 64 == 0) begin
				rx_pct = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(50, 10);
			end
		end
	end

	task automatic send_char(bit [7:0] c, bit last);
		int gap;
		if (!tail_phase && $urandom_range(99, 0) < tx_pct) begin
			gap = $urandom_range(5, 1);
			char_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_if.valid <= 1'b1;
		char_if.data  <= '{char_code: c, last_char: last};
		@(posedge clk);
		while (!char_if.ready) @(posedge clk);
		chars_sent++;
		if (chars_sent % 40 == 0) begin
			tx_pct = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(50, 10);
		end
	endtask

	task automatic send_text(text_t t);
		for (int i = 0; i < t.size(); i++) begin
			send_char(t[i], i == t.size() - 1);
		end
	endtask

	task automatic send_literal(string s);
		text_t t;
		for (int i = 0; i < s.len(); i++) begin
			t.push_back(s[i]);
		end
		send_text(t);
	endtask

	task automatic wait_drained();
		char_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic text_t make_text();
		text_t t;
		int kind;
		int ndig;
		int r;
		bit [7:0] picks[7];
		kind = $urandom_range(99, 0);
		if (kind >= 85 && kind < 95) begin
			repeat ($urandom_range(6, 1)) t.push_back(8'($urandom_range(255, 0)));
			return t;
		end
		r = $urandom_range(9, 0);
		ndig = (r < 6) ? $urandom_range(4, 1) : (r < 8) ? $urandom_range(15, 5) : $urandom_range(22, 16);
		repeat (ndig) t.push_back(8'(CH_ZERO + $urandom_range(9, 0)));
		if (kind >= 95) begin
			// near-miss suffix soup
			picks = '{CH_BIN, CH_BITS, CH_BYTES, "I", "k", "K", "x"};
			repeat ($urandom_range(4, 1)) begin
				if ($urandom_range(4, 0) == 0) begin
					t.push_back(8'(CH_ZERO + $urandom_range(9, 0)));
				end else begin
					t.push_back(picks[$urandom_range(6, 0)]);
				end
			end
			return t;
		end
		if ($urandom_range(9, 0) < 7) begin
			t.push_back(8'(UNIT_LETTERS[$urandom_range(UNIT_COUNT - 1, 0)]
				+ ($urandom_range(1, 0) ? CASE_OFFSET : 8'd0)));
		end
		if ($urandom_range(1, 0)) begin
			t.push_back(CH_BIN);
		end
		if ($urandom_range(9, 0) < 6) begin
			t.push_back($urandom_range(1, 0) ? CH_BITS : CH_BYTES);
		end
		if (kind >= 70) begin
			r = $urandom_range(t.size(), 0);
			if ($urandom_range(1, 0) || r == t.size()) begin
				t.insert(r, 8'($urandom_range(255, 0)));
			end else begin
				t[r] = 8'($urandom_range(255, 0));
			end
		end
		return t;
	endfunction

	initial begin
		bit paused;
		paused = 1'b0;
		sb = new();
		arst_n = 1'b0;
		char_if.valid = 1'b0;
		char_if.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_literal("0");
		send_literal("4KiB");
		send_literal("1yb");
		send_literal("x");
		send_literal("7iB");
		send_literal("2KB!");
		send_literal("16EiB");
		send_literal("0YiB");

		while (chars_sent < RANDOM_CHARS) begin
			if (chars_sent > 500) begin
				hold_go = 1'b1;
			end
			if (!paused && chars_sent > 1100) begin
				wait_drained();
				paused = 1'b1;
			end
			tail_phase = chars_sent > RANDOM_CHARS - TAIL_CHARS;
			send_text(make_text());
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
